>>> rtl/sialu_pkg.sv
// ----------------------------------------------------------------------------
// sialu_pkg: shared types and opcodes for the saturating integer ALU
// Transaction structs and opcode constants used by the ALU core and the top.
// ----------------------------------------------------------------------------
package sialu_pkg;

    typedef struct packed {
        logic [6:0]  req_type;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } sialu_req_t;

    typedef struct packed {
        logic [31:0] result_main;
        logic [15:0] result_second;
    } sialu_rsp_t;

    localparam logic [6:0] OPS_PER_GROUP = 7'd27;
    localparam logic [6:0] OP_WORD_BASE  = 7'd27;
    localparam logic [6:0] OP_LONG_BASE  = 7'd54;
    localparam logic [6:0] OP_MISC_BASE  = 7'd81;

    // per-element sub-opcodes
    localparam logic [4:0] SUB_ABS    = 5'd0;
    localparam logic [4:0] SUB_ADD    = 5'd1;
    localparam logic [4:0] SUB_ADDSS  = 5'd2;
    localparam logic [4:0] SUB_ADDUS  = 5'd3;
    localparam logic [4:0] SUB_AND    = 5'd4;
    localparam logic [4:0] SUB_ANDN   = 5'd5;
    localparam logic [4:0] SUB_AVGS   = 5'd6;
    localparam logic [4:0] SUB_AVGU   = 5'd7;
    localparam logic [4:0] SUB_CMPEQ  = 5'd8;
    localparam logic [4:0] SUB_CMPGTS = 5'd9;
    localparam logic [4:0] SUB_COPY   = 5'd10;
    localparam logic [4:0] SUB_MAXS   = 5'd11;
    localparam logic [4:0] SUB_MAXU   = 5'd12;
    localparam logic [4:0] SUB_MINS   = 5'd13;
    localparam logic [4:0] SUB_MINU   = 5'd14;
    localparam logic [4:0] SUB_MULL   = 5'd15;
    localparam logic [4:0] SUB_MULHS  = 5'd16;
    localparam logic [4:0] SUB_MULHU  = 5'd17;
    localparam logic [4:0] SUB_OR     = 5'd18;
    localparam logic [4:0] SUB_SHL    = 5'd19;
    localparam logic [4:0] SUB_SHRS   = 5'd20;
    localparam logic [4:0] SUB_SHRU   = 5'd21;
    localparam logic [4:0] SUB_SIGN   = 5'd22;
    localparam logic [4:0] SUB_SUB    = 5'd23;
    localparam logic [4:0] SUB_SUBSS  = 5'd24;
    localparam logic [4:0] SUB_SUBUS  = 5'd25;
    localparam logic [4:0] SUB_XOR    = 5'd26;

    // remaining opcodes
    localparam logic [6:0] OP_CONVSBW   = 7'd81;
    localparam logic [6:0] OP_CONVUBW   = 7'd82;
    localparam logic [6:0] OP_CONVSWL   = 7'd83;
    localparam logic [6:0] OP_CONVUWL   = 7'd84;
    localparam logic [6:0] OP_CONVWB    = 7'd85;
    localparam logic [6:0] OP_CONVSSSWB = 7'd86;
    localparam logic [6:0] OP_CONVSUSWB = 7'd87;
    localparam logic [6:0] OP_CONVUSSWB = 7'd88;
    localparam logic [6:0] OP_CONVUUSWB = 7'd89;
    localparam logic [6:0] OP_CONVLW    = 7'd90;
    localparam logic [6:0] OP_CONVSSSLW = 7'd91;
    localparam logic [6:0] OP_CONVSUSLW = 7'd92;
    localparam logic [6:0] OP_CONVUSSLW = 7'd93;
    localparam logic [6:0] OP_CONVUUSLW = 7'd94;
    localparam logic [6:0] OP_MULSBW    = 7'd95;
    localparam logic [6:0] OP_MULUBW    = 7'd96;
    localparam logic [6:0] OP_MULSWL    = 7'd97;
    localparam logic [6:0] OP_MULUWL    = 7'd98;
    localparam logic [6:0] OP_ACCW      = 7'd99;
    localparam logic [6:0] OP_ACCL      = 7'd100;
    localparam logic [6:0] OP_ACCSADUBL = 7'd101;
    localparam logic [6:0] OP_SWAPW     = 7'd102;
    localparam logic [6:0] OP_SWAPL     = 7'd103;
    localparam logic [6:0] OP_SELECT0WB = 7'd104;
    localparam logic [6:0] OP_SELECT1WB = 7'd105;
    localparam logic [6:0] OP_SELECT0LW = 7'd106;
    localparam logic [6:0] OP_SELECT1LW = 7'd107;
    localparam logic [6:0] OP_MERGEWL   = 7'd108;
    localparam logic [6:0] OP_MERGEBW   = 7'd109;
    localparam logic [6:0] OP_SPLITLW   = 7'd110;
    localparam logic [6:0] OP_SPLITWB   = 7'd111;

endpackage

>>> rtl/sialu_core.sv
// ----------------------------------------------------------------------------
// sialu_core: combinational ALU datapath
// Decodes the opcode into width and sub-op and evaluates one transaction.
// ----------------------------------------------------------------------------
module sialu_core
    import sialu_pkg::*;
(
    input  sialu_req_t req,
    output sialu_rsp_t rsp
);

    logic [1:0]  grp;
    logic [4:0]  sub;
    logic [31:0] m;
    logic [5:0]  w;
    logic [31:0] ua, ub;
    logic signed [32:0] sa, sb;
    logic signed [33:0] ssum, sdif;
    logic [32:0] usum, avgu;
    logic signed [33:0] avgs;
    logic [4:0]  n;
    logic signed [63:0] sprod;
    logic [63:0] uprod;
    logic signed [32:0] smax, smin;
    logic [31:0] r;
    logic [31:0] misc_r;
    logic [15:0] misc_r2;
    logic signed [32:0] sa16, sa32;
    logic [15:0] a16;
    logic [7:0]  a8, b8;

    always_comb
    begin
        if (req.req_type < OP_WORD_BASE)
        begin
            grp = 2'd0;
            sub = req.req_type[4:0];
        end
        else if (req.req_type < OP_LONG_BASE)
        begin
            grp = 2'd1;
            sub = 5'(req.req_type - OP_WORD_BASE);
        end
        else if (req.req_type < OP_MISC_BASE)
        begin
            grp = 2'd2;
            sub = 5'(req.req_type - OP_LONG_BASE);
        end
        else
        begin
            grp = 2'd3;
            sub = 5'd0;
        end
        case (grp)
            2'd0:    begin m = 32'h0000_00ff; w = 6'd8;  end
            2'd1:    begin m = 32'h0000_ffff; w = 6'd16; end
            default: begin m = 32'hffff_ffff; w = 6'd32; end
        endcase
    end

    always_comb
    begin
        ua = req.operand_a & m;
        ub = req.operand_b & m;
        case (grp)
            2'd0:
            begin
                sa = 33'(signed'(req.operand_a[7:0]));
                sb = 33'(signed'(req.operand_b[7:0]));
            end
            2'd1:
            begin
                sa = 33'(signed'(req.operand_a[15:0]));
                sb = 33'(signed'(req.operand_b[15:0]));
            end
            default:
            begin
                sa = 33'(signed'(req.operand_a));
                sb = 33'(signed'(req.operand_b));
            end
        endcase
        smax  = signed'({1'b0, m >> 1});
        smin  = -smax - 33'sd1;
        n     = req.operand_b[4:0] & 5'(w - 6'd1);
        ssum  = 34'(sa) + 34'(sb);
        sdif  = 34'(sa) - 34'(sb);
        usum  = {1'b0, ua} + {1'b0, ub};
        avgu  = 33'(({1'b0, usum} + 34'd1) >> 1);
        avgs  = (ssum + 34'sd1) >>> 1;
        sprod = 64'(sa) * 64'(sb);
        uprod = 64'(ua) * 64'(ub);

        case (sub)
            SUB_ABS:    r = sa[32] ? 32'(-sa) : sa[31:0];
            SUB_ADD:    r = usum[31:0];
            SUB_ADDSS:  r = (ssum < 34'(smin)) ? smin[31:0] :
                            ((ssum > 34'(smax)) ? smax[31:0] : ssum[31:0]);
            SUB_ADDUS:  r = (usum > {1'b0, m}) ? m : usum[31:0];
            SUB_AND:    r = ua & ub;
            SUB_ANDN:   r = ~ua & ub;
            SUB_AVGS:   r = avgs[31:0];
            SUB_AVGU:   r = avgu[31:0];
            SUB_CMPEQ:  r = (ua == ub) ? m : 32'd0;
            SUB_CMPGTS: r = (sa > sb) ? m : 32'd0;
            SUB_COPY:   r = ua;
            SUB_MAXS:   r = (sa > sb) ? sa[31:0] : sb[31:0];
            SUB_MAXU:   r = (ua > ub) ? ua : ub;
            SUB_MINS:   r = (sa < sb) ? sa[31:0] : sb[31:0];
            SUB_MINU:   r = (ua < ub) ? ua : ub;
            SUB_MULL:   r = uprod[31:0];
            SUB_MULHS:  r = 32'(sprod >>> w);
            SUB_MULHU:  r = 32'(uprod >> w);
            SUB_OR:     r = ua | ub;
            SUB_SHL:    r = ua << n;
            SUB_SHRS:   r = 32'(sa >>> n);
            SUB_SHRU:   r = ua >> n;
            SUB_SIGN:   r = sa[32] ? 32'hffff_ffff : ((sa != 33'sd0) ? 32'd1 : 32'd0);
            SUB_SUB:    r = ua - ub;
            SUB_SUBSS:  r = (sdif < 34'(smin)) ? smin[31:0] :
                            ((sdif > 34'(smax)) ? smax[31:0] : sdif[31:0]);
            SUB_SUBUS:  r = (ua < ub) ? 32'd0 : ua - ub;
            SUB_XOR:    r = ua ^ ub;
            default:    r = 32'd0;
        endcase
        r = r & m;
    end

    always_comb
    begin
        sa16 = 33'(signed'(req.operand_a[15:0]));
        sa32 = 33'(signed'(req.operand_a));
        a16  = req.operand_a[15:0];
        a8   = req.operand_a[7:0];
        b8   = req.operand_b[7:0];
        misc_r2 = 16'd0;
        case (req.req_type)
            OP_CONVSBW:   misc_r = {16'd0, {8{a8[7]}}, a8};
            OP_CONVUBW:   misc_r = {24'd0, a8};
            OP_CONVSWL:   misc_r = {{16{a16[15]}}, a16};
            OP_CONVUWL:   misc_r = {16'd0, a16};
            OP_CONVWB:    misc_r = {24'd0, a8};
            OP_CONVSSSWB: misc_r = (sa16 > 33'sd127) ? 32'd127 :
                                   ((sa16 < -33'sd128) ? 32'h80 : {24'd0, a8});
            OP_CONVSUSWB: misc_r = sa16[32] ? 32'd0 :
                                   ((sa16 > 33'sd255) ? 32'd255 : {24'd0, a8});
            OP_CONVUSSWB: misc_r = (a16 > 16'd127) ? 32'd127 : {16'd0, a16};
            OP_CONVUUSWB: misc_r = (a16 > 16'd255) ? 32'd255 : {16'd0, a16};
            OP_CONVLW:    misc_r = {16'd0, a16};
            OP_CONVSSSLW: misc_r = (sa32 > 33'sd32767) ? 32'd32767 :
                                   ((sa32 < -33'sd32768) ? 32'h8000 : {16'd0, a16});
            OP_CONVSUSLW: misc_r = sa32[32] ? 32'd0 :
                                   ((sa32 > 33'sd65535) ? 32'd65535 : {16'd0, a16});
            OP_CONVUSSLW: misc_r = (req.operand_a > 32'd32767) ? 32'd32767 : req.operand_a;
            OP_CONVUUSLW: misc_r = (req.operand_a > 32'd65535) ? 32'd65535 : req.operand_a;
            OP_MULSBW:    misc_r = {16'd0, 16'(signed'(a8) * signed'(b8))};
            OP_MULUBW:    misc_r = {16'd0, 16'(a8) * 16'(b8)};
            OP_MULSWL:    misc_r = 32'(signed'(a16) * signed'(req.operand_b[15:0]));
            OP_MULUWL:    misc_r = 32'(a16) * 32'(req.operand_b[15:0]);
            OP_ACCW:      misc_r = {16'd0, a16};
            OP_ACCL:      misc_r = req.operand_a;
            OP_ACCSADUBL: misc_r = {24'd0, (a8 >= b8) ? a8 - b8 : b8 - a8};
            OP_SWAPW:     misc_r = {16'd0, a8, req.operand_a[15:8]};
            OP_SWAPL:     misc_r = {a8, req.operand_a[15:8], req.operand_a[23:16],
                                    req.operand_a[31:24]};
            OP_SELECT0WB: misc_r = {24'd0, a8};
            OP_SELECT1WB: misc_r = {24'd0, req.operand_a[15:8]};
            OP_SELECT0LW: misc_r = {16'd0, a16};
            OP_SELECT1LW: misc_r = {16'd0, req.operand_a[31:16]};
            OP_MERGEWL:   misc_r = {req.operand_b[15:0], a16};
            OP_MERGEBW:   misc_r = {16'd0, b8, a8};
            OP_SPLITLW:
            begin
                misc_r  = {16'd0, req.operand_a[31:16]};
                misc_r2 = a16;
            end
            OP_SPLITWB:
            begin
                misc_r  = {24'd0, req.operand_a[15:8]};
                misc_r2 = {8'd0, a8};
            end
            default:      misc_r = 32'd0;
        endcase
    end

    assign rsp.result_main   = (grp == 2'd3) ? misc_r : r;
    assign rsp.result_second = (grp == 2'd3) ? misc_r2 : 16'd0;

endmodule

>>> rtl/saturating_integer_alu_8_16_32_top.sv
// ----------------------------------------------------------------------------
// saturating_integer_alu_8_16_32_top: SIMD-style saturating integer ALU
// Registers the request, evaluates it in one pass, registers the result.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/stall | sialu_req_t (req_type, operand_a/b)
//  out     | output    | out_valid/stall| sialu_rsp_t (result_main, _second)
//
// One transaction per cycle sustained while out_stall stays low; two register
// stages (input register, then result register): an accepted request waits in
// req_reg for the core, then loads into rsp_reg, which raises out_valid.
// Reset (rst_n, async low) clears only the two valid flags.
// in_stall rises only when both stages are full and the output is stalled;
// the pipeline advances as a whole whenever the result stage can move.
// ----------------------------------------------------------------------------
module saturating_integer_alu_8_16_32_top
    import sialu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  sialu_req_t in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output sialu_rsp_t out_data
);

    logic       req_valid_reg;
    sialu_req_t req_reg;
    logic       rsp_valid_reg;
    sialu_rsp_t rsp_reg;
    sialu_rsp_t rsp_next;
    logic       rsp_move;
    logic       req_move;

    // result stage loads when empty or its transaction is leaving
    assign rsp_move = !rsp_valid_reg || !out_stall;
    // request stage loads when empty or its transaction moves on
    assign req_move = !req_valid_reg || rsp_move;
    assign in_stall = !req_move;

    sialu_core u_core (
        .req (req_reg),
        .rsp (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_move)
                req_valid_reg <= in_valid;
            if (rsp_move)
                rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_move && in_valid)
            req_reg <= in_data;
        if (rsp_move && req_valid_reg)
            rsp_reg <= rsp_next;
    end

    assign out_valid = rsp_valid_reg;
    assign out_data  = rsp_reg;

endmodule
